>>> sv/gha_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the generational handle allocator.
// No dependencies; used by every other file of the block.
package gha_pkg;

    localparam int MAX_SLOTS_DEF       = 1024;
    localparam int GENERATION_WRAP_DEF = 256;
    localparam int SIGNATURE_BITS_DEF  = 32;

    // operation codes
    localparam logic [2:0] FUNC_CREATE  = 3'd0;
    localparam logic [2:0] FUNC_DESTROY = 3'd1;
    localparam logic [2:0] FUNC_QUERY   = 3'd2;
    localparam logic [2:0] FUNC_SET_SIG = 3'd3;
    localparam logic [2:0] FUNC_GET_SIG = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_NOT_ALIVE = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] entity_index;
        logic [7:0]  entity_generation;
        logic [31:0] signature_in;
    } gha_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  handle_index;
        logic [7:0]  handle_generation;
        logic        alive_flag;
        logic [31:0] signature_out;
        logic [10:0] live_count;
        logic [31:0] created_total;
    } gha_rsp_t;

endpackage

>>> sv/gha_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on gha_pkg for default sizes.
module gha_ram #(
    parameter int DEPTH = gha_pkg::MAX_SLOTS_DEF,
    parameter int DW    = $clog2(gha_pkg::MAX_SLOTS_DEF)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/generational_handle_allocator.sv
`timescale 1ns / 1ps
// Top level of the generational handle allocator: control, counters and the two RAMs.
// Depends on gha_pkg and gha_ram.

// After reset the block runs a clearing pass over every slot, loading the free
// stack with every slot index and zeroing the slot table, and takes no word until it
// is done. From then on the slot table is read in the accept cycle and written back
// when the result is registered, and only then is the next word accepted. A successful
// create first passes through a pop state, since the slot to touch comes out of the
// free stack RAM before the slot table can be read. A result that is not taken holds
// the block in its write-back step until the output register frees.
module generational_handle_allocator #(
    parameter int MAX_SLOTS       = gha_pkg::MAX_SLOTS_DEF,
    parameter int GENERATION_WRAP = gha_pkg::GENERATION_WRAP_DEF,
    parameter int SIGNATURE_BITS  = gha_pkg::SIGNATURE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  gha_pkg::gha_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output gha_pkg::gha_rsp_t rsp
);

    localparam int IW     = $clog2(MAX_SLOTS);
    localparam int CW     = $clog2(MAX_SLOTS + 1);
    localparam int GW     = $clog2(GENERATION_WRAP);
    localparam int GCW    = (GW > 8) ? GW : 8;
    localparam int SW     = SIGNATURE_BITS;
    localparam int SLOT_W = 1 + GW + SW;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_POP   = 4'b0100,
        ST_EXEC  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     top_reg, top_next;
    logic [CW-1:0]     live_reg, live_next;
    logic [31:0]       created_reg, created_next;
    logic [IW-1:0]     slot_reg, slot_next;
    gha_pkg::gha_req_t req_reg;
    gha_pkg::gha_rsp_t rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              accept, out_free, commit, empty;
    logic              in_range, match, create_ok, destroy_ok, set_ok;

    logic              stk_rd_en, stk_wr_en;
    logic [IW-1:0]     stk_rd_addr, stk_wr_addr, stk_wr_data, stk_rd_data, pop_slot;
    logic              slt_rd_en, slt_wr_en;
    logic [IW-1:0]     slt_rd_addr, slt_wr_addr;
    logic [SLOT_W-1:0] slt_wr_data, slt_rd_data;

    logic              rd_alive;
    logic [GW-1:0]     rd_gen, gen_inc;
    logic [SW-1:0]     rd_sig, sig_wr;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign commit    = (state_reg == ST_EXEC) && out_free;
    assign empty     = (top_reg == '0);

    // stale entries past the slot range would be corrupt; fall back to slot zero
    assign pop_slot = ({1'b0, stk_rd_data} < (IW + 1)'(MAX_SLOTS)) ? stk_rd_data : '0;

    assign rd_alive = slt_rd_data[SLOT_W-1];
    assign rd_gen   = slt_rd_data[SW +: GW];
    assign rd_sig   = slt_rd_data[SW-1:0];
    assign gen_inc  = (rd_gen == GW'(GENERATION_WRAP - 1)) ? '0 : rd_gen + 1'b1;
    assign sig_wr   = SW'(req_reg.signature_in);

    assign in_range   = {1'b0, req_reg.entity_index} < 17'(MAX_SLOTS);
    assign match      = rd_alive && (GCW'(rd_gen) == GCW'(req_reg.entity_generation));
    assign create_ok  = (req_reg.func == gha_pkg::FUNC_CREATE) && !empty;
    assign destroy_ok = (req_reg.func == gha_pkg::FUNC_DESTROY) && in_range && match;
    assign set_ok     = (req_reg.func == gha_pkg::FUNC_SET_SIG) && in_range;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next = req.entity_index[IW-1:0];
                    if ((req.func == gha_pkg::FUNC_CREATE) && !empty)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_POP:
            begin
                slot_next  = pop_slot;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // RAM ports
    always_comb
    begin
        stk_rd_en   = accept && (req.func == gha_pkg::FUNC_CREATE) && !empty;
        stk_rd_addr = IW'(top_reg - 1'b1);
        slt_rd_en   = (accept && (req.func != gha_pkg::FUNC_CREATE)) || (state_reg == ST_POP);
        slt_rd_addr = (state_reg == ST_POP) ? pop_slot : req.entity_index[IW-1:0];

        stk_wr_en   = 1'b0;
        stk_wr_addr = top_reg[IW-1:0];
        stk_wr_data = slot_reg;
        slt_wr_en   = 1'b0;
        slt_wr_addr = slot_reg;
        slt_wr_data = {rd_alive, rd_gen, sig_wr};

        if (state_reg == ST_CLEAR)
        begin
            stk_wr_en   = 1'b1;
            stk_wr_addr = clr_reg;
            stk_wr_data = clr_reg;
            slt_wr_en   = 1'b1;
            slt_wr_addr = clr_reg;
            slt_wr_data = '0;
        end
        else if (commit)
        begin
            priority if (create_ok)
            begin
                slt_wr_en   = 1'b1;
                slt_wr_data = {1'b1, gen_inc, {SW{1'b0}}};
            end
            else if (destroy_ok)
            begin
                slt_wr_en   = 1'b1;
                slt_wr_data = {1'b0, rd_gen, rd_sig};
                stk_wr_en   = (top_reg < CW'(MAX_SLOTS));
            end
            else if (set_ok)
            begin
                slt_wr_en = 1'b1;
            end
            else
            begin
                slt_wr_en = 1'b0;
            end
        end
    end

    // counters
    always_comb
    begin
        top_next     = top_reg;
        live_next    = live_reg;
        created_next = created_reg;
        if (commit && create_ok)
        begin
            top_next     = top_reg - 1'b1;
            live_next    = live_reg + 1'b1;
            created_next = created_reg + 32'd1;
        end
        else if (commit && destroy_ok)
        begin
            if (live_reg != '0)
            begin
                live_next = live_reg - 1'b1;
            end
            if (top_reg < CW'(MAX_SLOTS))
            begin
                top_next = top_reg + 1'b1;
            end
        end
    end

    // result word
    always_comb
    begin
        rsp_next = '0;
        if ((req_reg.func != gha_pkg::FUNC_CREATE) && (req_reg.func <= gha_pkg::FUNC_GET_SIG))
        begin
            rsp_next.handle_index = req_reg.entity_index[9:0];
            if (!in_range)
            begin
                rsp_next.status = gha_pkg::STATUS_RANGE;
            end
        end
        unique case (req_reg.func)
            gha_pkg::FUNC_CREATE:
            begin
                if (empty)
                begin
                    rsp_next.status = gha_pkg::STATUS_NO_FREE;
                end
                else
                begin
                    rsp_next.handle_index      = 10'(slot_reg);
                    rsp_next.handle_generation = 8'(gen_inc);
                end
            end
            gha_pkg::FUNC_DESTROY:
            begin
                if (in_range && !match)
                begin
                    rsp_next.status = gha_pkg::STATUS_NOT_ALIVE;
                end
            end
            gha_pkg::FUNC_QUERY:
            begin
                rsp_next.alive_flag = in_range && match;
            end
            gha_pkg::FUNC_SET_SIG:
            begin
            end
            gha_pkg::FUNC_GET_SIG:
            begin
                if (in_range)
                begin
                    rsp_next.signature_out = 32'(rd_sig);
                end
            end
            default:
            begin
                rsp_next.status = gha_pkg::STATUS_OK;
            end
        endcase
        rsp_next.live_count    = 11'(live_next);
        rsp_next.created_total = created_next;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            top_reg       <= CW'(MAX_SLOTS);
            live_reg      <= '0;
            created_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            top_reg       <= top_next;
            live_reg      <= live_next;
            created_reg   <= created_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (accept)
        begin
            req_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    gha_ram #(
        .DEPTH (MAX_SLOTS),
        .DW    (IW)
    ) u_free_stack (
        .clk     (clk),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data)
    );

    gha_ram #(
        .DEPTH (MAX_SLOTS),
        .DW    (SLOT_W)
    ) u_slot_table (
        .clk     (clk),
        .rd_en   (slt_rd_en),
        .rd_addr (slt_rd_addr),
        .rd_data (slt_rd_data),
        .wr_en   (slt_wr_en),
        .wr_addr (slt_wr_addr),
        .wr_data (slt_wr_data)
    );

    // every slot is either on the free stack or alive
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW + 1)'(top_reg) + (CW + 1)'(live_reg)) == (CW + 1)'(MAX_SLOTS))
        else $error("free and live counts out of step");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CW'(MAX_SLOTS))
        else $error("free stack pointer past depth");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result word raised outside write-back");

    a_create_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && create_ok) |=> (created_reg == $past(created_reg) + 32'd1))
        else $error("creation counter missed a create");

endmodule

>>> test/generational_handle_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator: directed words, then
// random mixes, churn, fill and drain runs, with random idling on both channels.
// Depends on gha_pkg and the block's RTL.

class alloc_scoreboard;
    logic [9:0]        free_stack [gha_pkg::MAX_SLOTS_DEF];
    int                free_top;
    logic [7:0]        slot_gen [gha_pkg::MAX_SLOTS_DEF];
    bit                slot_alive [gha_pkg::MAX_SLOTS_DEF];
    logic [31:0]       slot_sig [gha_pkg::MAX_SLOTS_DEF];
    logic [10:0]       live_total;
    logic [31:0]       creation_count;
    int                live_slots [$];
    gha_pkg::gha_rsp_t awaited_rsp [$];
    int                mismatches;
    int                results_checked;
    int                status_count [4];

    function new();
        for (int i = 0; i < gha_pkg::MAX_SLOTS_DEF; i++)
        begin
            free_stack[i] = 10'(i);
            slot_gen[i]   = '0;
            slot_alive[i] = 1'b0;
            slot_sig[i]   = '0;
        end
        free_top        = gha_pkg::MAX_SLOTS_DEF;
        live_total      = '0;
        creation_count  = '0;
        mismatches      = 0;
        results_checked = 0;
        for (int i = 0; i < 4; i++)
            status_count[i] = 0;
    endfunction

    task report(string what, longint exp_val, longint got_val);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t: %s expected %0h got %0h", $time, what, exp_val, got_val);
    endtask

    // Works out the allocator's answer to one accepted word and updates the copy of its state.
    function void note_request(gha_pkg::gha_req_t w);
        gha_pkg::gha_rsp_t e;
        int                idx;
        int                s;
        bit                in_range;
        bit                hit;
        int                pos [$];
        e        = '0;
        idx      = int'(w.entity_index);
        in_range = idx < gha_pkg::MAX_SLOTS_DEF;
        hit      = 1'b0;
        if (in_range)
            hit = slot_alive[idx] && slot_gen[idx] == w.entity_generation;
        if (w.func != gha_pkg::FUNC_CREATE && w.func <= gha_pkg::FUNC_GET_SIG)
        begin
            e.handle_index = w.entity_index[9:0];
            if (!in_range)
                e.status = gha_pkg::STATUS_RANGE;
        end
        case (w.func)
            gha_pkg::FUNC_CREATE:
                if (free_top == 0)
                    e.status = gha_pkg::STATUS_NO_FREE;
                else
                begin
                    free_top--;
                    s = int'(free_stack[free_top]);
                    slot_gen[s]   = 8'((int'(slot_gen[s]) + 1) % gha_pkg::GENERATION_WRAP_DEF);
                    slot_alive[s] = 1'b1;
                    slot_sig[s]   = '0;
                    live_total++;
                    creation_count++;
                    live_slots.insert(live_slots.size(), s);
                    e.handle_index      = 10'(s);
                    e.handle_generation = slot_gen[s];
                end
            gha_pkg::FUNC_DESTROY:
                if (in_range)
                begin
                    if (!hit)
                        e.status = gha_pkg::STATUS_NOT_ALIVE;
                    else
                    begin
                        slot_alive[idx] = 1'b0;
                        if (live_total > 0)
                            live_total--;
                        if (free_top < gha_pkg::MAX_SLOTS_DEF)
                        begin
                            free_stack[free_top] = 10'(idx);
                            free_top++;
                        end
                        pos = live_slots.find_first_index(x) with (x == idx);
                        if (pos.size() > 0)
                            live_slots.delete(pos[0]);
                    end
                end
            gha_pkg::FUNC_QUERY:
                if (in_range)
                    e.alive_flag = hit;
            gha_pkg::FUNC_SET_SIG:
                if (in_range)
                    slot_sig[idx] = w.signature_in;
            gha_pkg::FUNC_GET_SIG:
                if (in_range)
                    e.signature_out = slot_sig[idx];
            default:
                ;
        endcase
        e.live_count    = live_total;
        e.created_total = creation_count;
        status_count[e.status]++;
        awaited_rsp.insert(awaited_rsp.size(), e);
    endfunction

    task check_response(gha_pkg::gha_rsp_t r);
        gha_pkg::gha_rsp_t e;
        results_checked++;
        if (awaited_rsp.size() == 0)
        begin
            report("word with nothing awaited, status", 0, r.status);
            return;
        end
        e = awaited_rsp.pop_front();
        if (r.status !== e.status)
            report("status", e.status, r.status);
        if (r.handle_index !== e.handle_index)
            report("handle_index", e.handle_index, r.handle_index);
        if (r.handle_generation !== e.handle_generation)
            report("handle_generation", e.handle_generation, r.handle_generation);
        if (r.alive_flag !== e.alive_flag)
            report("alive_flag", e.alive_flag, r.alive_flag);
        if (r.signature_out !== e.signature_out)
            report("signature_out", e.signature_out, r.signature_out);
        if (r.live_count !== e.live_count)
            report("live_count", e.live_count, r.live_count);
        if (r.created_total !== e.created_total)
            report("created_total", e.created_total, r.created_total);
    endtask
endclass

module generational_handle_allocator_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {MIX_MODE, CHURN_MODE, FILL_MODE, DRAIN_MODE} stim_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    gha_pkg::gha_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    gha_pkg::gha_rsp_t rsp;

    alloc_scoreboard sb = new();

    int cycle_count        = 0;
    int words_sent         = 0;
    bit send_fast          = 1'b0;
    int send_run           = 60;
    bit rsp_fast           = 1'b0;
    int rsp_run            = 50;
    int hold_asks          = 0;
    int holds_done         = 0;
    bit churn_destroy_next = 1'b0;
    bit fill_hold_asked    = 1'b0;

    generational_handle_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("generational_handle_allocator test failed");
            $finish;
        end
    end

    function automatic gha_pkg::gha_req_t make_word(logic [2:0] f, logic [15:0] idx,
                                                    logic [7:0] gen, logic [31:0] sig);
        gha_pkg::gha_req_t w;
        w.func              = f;
        w.entity_index      = idx;
        w.entity_generation = gen;
        w.signature_in      = sig;
        return w;
    endfunction

    function automatic gha_pkg::gha_req_t random_word(stim_mode_t mode);
        gha_pkg::gha_req_t w;
        int                roll;
        int                pick;
        int                n;
        int                s;
        logic [2:0]        unused_f;
        w.func              = gha_pkg::FUNC_CREATE;
        w.entity_index      = 16'($urandom_range(0, gha_pkg::MAX_SLOTS_DEF - 1));
        w.entity_generation = 8'($urandom_range(0, 255));
        w.signature_in      = $urandom();
        unused_f            = gha_pkg::FUNC_GET_SIG + 3'($urandom_range(1, 3));
        n    = sb.live_slots.size();
        roll = $urandom_range(0, 99);
        case (mode)
            MIX_MODE:
                w.func = roll < 25 ? gha_pkg::FUNC_CREATE :
                         roll < 45 ? gha_pkg::FUNC_DESTROY :
                         roll < 60 ? gha_pkg::FUNC_QUERY :
                         roll < 75 ? gha_pkg::FUNC_SET_SIG :
                         roll < 93 ? gha_pkg::FUNC_GET_SIG : unused_f;
            FILL_MODE:
                w.func = roll < 95 ? gha_pkg::FUNC_CREATE :
                         roll < 96 ? gha_pkg::FUNC_DESTROY :
                         roll < 97 ? gha_pkg::FUNC_QUERY :
                         roll < 98 ? gha_pkg::FUNC_SET_SIG :
                         roll < 99 ? gha_pkg::FUNC_GET_SIG : unused_f;
            DRAIN_MODE:
                w.func = roll < 10 ? gha_pkg::FUNC_CREATE :
                         roll < 70 ? gha_pkg::FUNC_DESTROY :
                         roll < 80 ? gha_pkg::FUNC_QUERY :
                         roll < 88 ? gha_pkg::FUNC_SET_SIG :
                         roll < 96 ? gha_pkg::FUNC_GET_SIG : unused_f;
            default:
            begin
                // churn: create and destroy the newest slot in turn, hitting one entry repeatedly
                if (roll < 6 && n > 0)
                begin
                    s = sb.live_slots[n - 1];
                    w.func              = roll < 2 ? gha_pkg::FUNC_QUERY :
                                          roll < 4 ? gha_pkg::FUNC_SET_SIG :
                                          gha_pkg::FUNC_GET_SIG;
                    w.entity_index      = 16'(s);
                    w.entity_generation = sb.slot_gen[s];
                end
                else if (churn_destroy_next && n > 0)
                begin
                    s = sb.live_slots[n - 1];
                    w.func              = gha_pkg::FUNC_DESTROY;
                    w.entity_index      = 16'(s);
                    w.entity_generation = sb.slot_gen[s];
                    churn_destroy_next  = 1'b0;
                end
                else
                begin
                    w.entity_index     = 16'($urandom_range(0, 65535));
                    churn_destroy_next = 1'b1;
                end
                return w;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (w.func == gha_pkg::FUNC_CREATE || w.func > gha_pkg::FUNC_GET_SIG)
        begin
            if (pick < 30)
                w.entity_index = 16'($urandom_range(0, 65535));
        end
        else if (pick < 70 && n > 0)
        begin
            s = sb.live_slots[$urandom_range(0, n - 1)];
            w.entity_index      = 16'(s);
            w.entity_generation = sb.slot_gen[s];
        end
        else if (pick < 80 && n > 0)
        begin
            // live slot, stale generation
            s = sb.live_slots[$urandom_range(0, n - 1)];
            w.entity_index      = 16'(s);
            w.entity_generation = sb.slot_gen[s] + 8'($urandom_range(1, 255));
        end
        else if (pick >= 92)
            w.entity_index = 16'($urandom_range(gha_pkg::MAX_SLOTS_DEF, 65535));
        return w;
    endfunction

    task automatic send_word(input gha_pkg::gha_req_t w);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(w);
        words_sent++;
        send_run--;
        if (send_run == 0)
        begin
            send_fast = !send_fast;
            send_run  = $urandom_range(40, 120);
        end
    endtask

    task automatic run_words(input stim_mode_t mode, input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word(mode));
    endtask

    // receiver: random stalls, stretches without any, and the odd long hold-off
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holds_done < hold_asks)
            begin
                holds_done++;
                stall = HOLD_CYCLES;
            end
            else
                stall = rsp_fast ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            sb.check_response(rsp);
            rsp_run--;
            if (rsp_run == 0)
            begin
                rsp_fast = !rsp_fast;
                rsp_run  = $urandom_range(30, 100);
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: never-used slot, dead-slot signature, create/destroy, stale and out-of-range
        send_word(make_word(gha_pkg::FUNC_QUERY,   16'd0,    8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_DESTROY, 16'd0,    8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_GET_SIG, 16'd1023, 8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_SET_SIG, 16'd5,    8'd0,  32'hFFFF_FFFF));
        send_word(make_word(gha_pkg::FUNC_GET_SIG, 16'd5,    8'hFF, 32'h0));
        send_word(make_word(gha_pkg::FUNC_CREATE,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        send_word(make_word(gha_pkg::FUNC_GET_SIG, 16'd1023, 8'd1,  32'h0));
        send_word(make_word(gha_pkg::FUNC_SET_SIG, 16'd1023, 8'd1,  32'hA5A5_5A5A));
        send_word(make_word(gha_pkg::FUNC_QUERY,   16'd1023, 8'd1,  32'h0));
        send_word(make_word(gha_pkg::FUNC_QUERY,   16'd1023, 8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_DESTROY, 16'd1023, 8'd2,  32'h0));
        send_word(make_word(gha_pkg::FUNC_DESTROY, 16'd1023, 8'd1,  32'h0));
        send_word(make_word(gha_pkg::FUNC_DESTROY, 16'd1023, 8'd1,  32'h0));
        send_word(make_word(gha_pkg::FUNC_CREATE,  16'd0,    8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_GET_SIG, 16'd1023, 8'd2,  32'h0));
        send_word(make_word(gha_pkg::FUNC_QUERY,   16'd1024, 8'd2,  32'h0));
        send_word(make_word(gha_pkg::FUNC_DESTROY, 16'hFFFF, 8'hFF, 32'h0));
        send_word(make_word(gha_pkg::FUNC_SET_SIG, 16'h8000, 8'd0,  32'h1234_5678));
        send_word(make_word(gha_pkg::FUNC_GET_SIG, 16'hFFFF, 8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_GET_SIG + 3'd1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        send_word(make_word(gha_pkg::FUNC_GET_SIG + 3'd2, 16'd3,    8'd0,  32'h0));
        send_word(make_word(gha_pkg::FUNC_GET_SIG + 3'd3, 16'd1023, 8'h55, 32'hAAAA_AAAA));

        run_words(MIX_MODE, 60);
        hold_asks <= hold_asks + 1;
        run_words(MIX_MODE, 30);

        run_words(CHURN_MODE, 40);

        // fill until the free stack is empty, then keep creating into the empty stack
        while (sb.free_top > 0)
        begin
            if (!fill_hold_asked && sb.free_top < 600)
            begin
                fill_hold_asked = 1'b1;
                hold_asks <= hold_asks + 1;
            end
            send_word(random_word(FILL_MODE));
        end
        run_words(FILL_MODE, 20);

        run_words(DRAIN_MODE, 40);

        req_valid <= 1'b0;
        while (sb.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("%0d words sent, %0d results checked: %0d creates, %0d with no free slot,",
                 words_sent, sb.results_checked, sb.creation_count,
                 sb.status_count[gha_pkg::STATUS_NO_FREE]);
        $display("%0d out of range, %0d dead or stale handles, %0d hold-offs",
                 sb.status_count[gha_pkg::STATUS_RANGE],
                 sb.status_count[gha_pkg::STATUS_NOT_ALIVE], holds_done);
        if (sb.mismatches == 0)
            $display("generational_handle_allocator test passed");
        else
            $display("generational_handle_allocator test failed");
        $finish;
    end

endmodule
